FILE: design/msr_pkg.sv
// Package with the shared types, constants and saturation helpers of the slope reconstruction.
`timescale 1ns / 1ps
package msr_pkg;

  localparam int ValueBits = 32;
  localparam int WidthBits = 31;
  localparam int FractionBits = 16;
  localparam int HalfShift = FractionBits + 1;
  localparam int MagBits = ValueBits + 1;
  localparam int DenBits = WidthBits + 1;
  localparam int DigitBits = 4;
  localparam int NumBits = ((MagBits + HalfShift + DigitBits - 1) / DigitBits) * DigitBits;
  localparam int DivSteps = NumBits / DigitBits;
  localparam int ProdBits = ValueBits + WidthBits;
  localparam int Lanes = 3;

  typedef logic signed [ValueBits-1:0] value_t;
  typedef logic [WidthBits-1:0] cwidth_t;
  typedef logic [DenBits-1:0] den_t;
  typedef logic [MagBits-1:0] mag_t;
  typedef logic [NumBits-1:0] quot_t;
  typedef logic [ProdBits-1:0] prod_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_A,
    ST_OUT_A,
    ST_UPD,
    ST_MUL_B,
    ST_OUT_B
  } state_t;

  // Control that the sequencer hands to every lane.
  typedef struct packed {
    logic div_start;
    logic div_step;
    logic mul_en;
  } lane_ctl_t;

  typedef struct packed {
    value_t left;
    value_t right;
  } lane_res_t;

  localparam value_t VMax = {1'b0, {(ValueBits-1){1'b1}}};
  localparam value_t VMin = {1'b1, {(ValueBits-1){1'b0}}};

  // Saturate a magnitude with a sign to a signed value.
  function automatic value_t sat_mag(input logic [ProdBits-HalfShift-1:0] mag, input logic neg);
    value_t res;
    if (neg) begin
      if (mag >= (ProdBits-HalfShift)'({1'b1, {(ValueBits-1){1'b0}}})) res = VMin;
      else res = -value_t'(mag[ValueBits-1:0]);
    end else begin
      if (mag > (ProdBits-HalfShift)'(VMax)) res = VMax;
      else res = value_t'(mag[ValueBits-1:0]);
    end
    return res;
  endfunction

  // Saturating sum of two signed values.
  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [ValueBits:0] s;
    value_t res;
    s = {a[ValueBits-1], a} + {b[ValueBits-1], b};
    if (s[ValueBits] != s[ValueBits-1]) res = s[ValueBits] ? VMin : VMax;
    else res = s[ValueBits-1:0];
    return res;
  endfunction

endpackage

FILE: design/msr_if.sv
// Channel interfaces for the cell input and the interface-state output.
`timescale 1ns / 1ps
interface msr_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] density;
  logic signed [31:0] pressure;
  logic signed [31:0] celerity;
  logic [30:0] cell_width;
  logic first_cell;
  logic last_cell;

  modport source(output valid, density, pressure, celerity, cell_width, first_cell, last_cell,
                 input ready);
  modport sink(input valid, density, pressure, celerity, cell_width, first_cell, last_cell,
               output ready);
endinterface

interface msr_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] left_density;
  logic signed [31:0] left_pressure;
  logic signed [31:0] left_celerity;
  logic signed [31:0] right_density;
  logic signed [31:0] right_pressure;
  logic signed [31:0] right_celerity;
  logic final_interface;

  modport source(output valid, left_density, left_pressure, left_celerity, right_density,
                 right_pressure, right_celerity, final_interface, input ready);
  modport sink(input valid, left_density, left_pressure, left_celerity, right_density,
               right_pressure, right_celerity, final_interface, output ready);
endinterface

FILE: design/msr_div.sv
// Radix-16 restoring divider for the scaled edge-slope magnitude.
`timescale 1ns / 1ps
module msr_div (
  input  logic           clk,
  input  logic           start,
  input  logic           step,
  input  msr_pkg::mag_t  mag,
  input  msr_pkg::den_t  den,
  output msr_pkg::quot_t quot
);

  logic [msr_pkg::DenBits-1:0] rem_r, rem_nxt;
  msr_pkg::quot_t num_r, num_nxt, q_r, q_nxt;
  msr_pkg::den_t den_r;

  // Four quotient bits per cycle while step is high.
  always_comb begin
    logic [msr_pkg::DenBits:0] rt;
    msr_pkg::quot_t nt, qt;
    rt = {1'b0, rem_r};
    nt = num_r;
    qt = q_r;
    for (int i = 0; i < msr_pkg::DigitBits; i++) begin
      rt = {rt[msr_pkg::DenBits-1:0], nt[msr_pkg::NumBits-1]};
      nt = {nt[msr_pkg::NumBits-2:0], 1'b0};
      if (rt >= {1'b0, den_r}) begin
        rt = rt - {1'b0, den_r};
        qt = {qt[msr_pkg::NumBits-2:0], 1'b1};
      end else begin
        qt = {qt[msr_pkg::NumBits-2:0], 1'b0};
      end
    end
    rem_nxt = rt[msr_pkg::DenBits-1:0];
    num_nxt = nt;
    q_nxt = qt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r <= '0;
      den_r <= den;
      num_r <= msr_pkg::NumBits'({mag, {msr_pkg::HalfShift{1'b0}}});
    end else if (step) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      q_r <= q_nxt;
    end
  end

  assign quot = q_r;

endmodule

FILE: design/msr_lane.sv
// One quantity lane: edge slope, minmod limiter and the two half-width products.
`timescale 1ns / 1ps
module msr_lane (
  input  logic               clk,
  input  msr_pkg::lane_ctl_t ctl,
  input  msr_pkg::value_t    cur,
  input  msr_pkg::value_t    prev,
  input  msr_pkg::den_t      den,
  input  msr_pkg::value_t    held_edge,
  input  msr_pkg::value_t    lv,
  input  msr_pkg::cwidth_t   lw,
  input  msr_pkg::value_t    ls,
  input  msr_pkg::value_t    rv,
  input  msr_pkg::cwidth_t   rw,
  input  logic               rs_zero,
  output msr_pkg::value_t    edge_slope,
  output msr_pkg::value_t    cell_slope,
  output msr_pkg::lane_res_t res
);

  logic signed [msr_pkg::MagBits-1:0] diff;
  msr_pkg::mag_t mag;
  msr_pkg::quot_t quot;
  logic neg_r, zero_r;
  msr_pkg::value_t rs;
  msr_pkg::prod_t prod_l_r, prod_r_r;
  logic neg_l_r, neg_r_r;

  // Difference of the neighboring cells and its magnitude.
  assign diff = {cur[msr_pkg::ValueBits-1], cur} - {prev[msr_pkg::ValueBits-1], prev};
  assign mag = diff[msr_pkg::MagBits-1] ? msr_pkg::mag_t'(-diff) : msr_pkg::mag_t'(diff);

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg_r <= diff[msr_pkg::MagBits-1];
      zero_r <= (diff == '0) || (den == '0);
    end
  end

  msr_div u_div (
    .clk  (clk),
    .start(ctl.div_start),
    .step (ctl.div_step),
    .mag  (mag),
    .den  (den),
    .quot (quot)
  );

  // Saturated edge slope, then the minmod of the held and the new edge slope of the cell.
  always_comb begin
    if (zero_r) edge_slope = '0;
    else edge_slope = msr_pkg::sat_mag(quot[msr_pkg::ProdBits-msr_pkg::HalfShift-1:0] |
        {(msr_pkg::ProdBits-msr_pkg::HalfShift){|quot[msr_pkg::NumBits-1:
        msr_pkg::ProdBits-msr_pkg::HalfShift]}}, neg_r);
    if (held_edge > 0 && edge_slope > 0)
      cell_slope = (held_edge < edge_slope) ? held_edge : edge_slope;
    else if (held_edge < 0 && edge_slope < 0)
      cell_slope = (held_edge > edge_slope) ? held_edge : edge_slope;
    else
      cell_slope = '0;
  end

  assign rs = rs_zero ? '0 : cell_slope;

  // Half-width products, registered before the shift and the sums. The magnitude is taken
  // as unsigned so that the most negative slope gives 2^(ValueBits-1).
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_l_r <= msr_pkg::prod_t'($unsigned(ls[msr_pkg::ValueBits-1] ? -ls : ls)) *
                  msr_pkg::prod_t'(lw);
      neg_l_r <= ls[msr_pkg::ValueBits-1];
      prod_r_r <= msr_pkg::prod_t'($unsigned(rs[msr_pkg::ValueBits-1] ? -rs : rs)) *
                  msr_pkg::prod_t'(rw);
      neg_r_r <= !rs[msr_pkg::ValueBits-1];
    end
  end

  assign res.left = msr_pkg::sat_add(lv, msr_pkg::sat_mag(
      prod_l_r[msr_pkg::ProdBits-1:msr_pkg::HalfShift], neg_l_r));
  assign res.right = msr_pkg::sat_add(rv, msr_pkg::sat_mag(
      prod_r_r[msr_pkg::ProdBits-1:msr_pkg::HalfShift], neg_r_r));

endmodule

FILE: design/minmod_slope_reconstruction.sv
// Top level: cell window, sequencer, three quantity lanes and the result merge.
// Each cell takes one transaction; the block then works on it alone and accepts the next cell
// only when done. A cell that opens a frame goes straight to the update; any other cell first
// runs the shared-width slope division (a load and thirteen steps of four quotient bits, run
// in all three lanes at once), and each result it emits (none, one or two) passes a product
// state and the output wait.
`timescale 1ns / 1ps
module minmod_slope_reconstruction (
  input logic     clk,
  input logic     rst_n,
  msr_in_if.sink  in_ch,
  msr_out_if.source out_ch
);

  msr_pkg::state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  msr_pkg::value_t win_val_r [0:5];
  msr_pkg::cwidth_t win_w_r [0:1];
  msr_pkg::value_t held_edge_r [0:2];
  msr_pkg::value_t held_cell_r [0:2];
  logic [1:0] seen_r;
  msr_pkg::value_t cur_val_r [0:2];
  msr_pkg::cwidth_t cur_w_r;
  logic last_r;

  msr_pkg::lane_ctl_t ctl;
  msr_pkg::den_t den;
  msr_pkg::value_t edge_s [0:2];
  msr_pkg::value_t cell_s [0:2];
  msr_pkg::lane_res_t res [0:2];
  logic accept, clear_all, do_upd;

  assign accept = in_ch.valid && in_ch.ready;
  assign den = {1'b0, win_w_r[1]} + {1'b0, cur_w_r};

  // Sequencer next state and lane control.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ctl = '0;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    clear_all = 1'b0;
    do_upd = 1'b0;
    unique case (state_r)
      msr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cnt_nxt = '0;
          if (in_ch.first_cell || seen_r == 2'd0) state_nxt = msr_pkg::ST_UPD;
          else state_nxt = msr_pkg::ST_DIV;
        end
      end
      msr_pkg::ST_DIV: begin
        if (cnt_r == 4'd0) ctl.div_start = 1'b1;
        else ctl.div_step = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(msr_pkg::DivSteps))
          state_nxt = (seen_r == 2'd2) ? msr_pkg::ST_MUL_A : msr_pkg::ST_UPD;
      end
      msr_pkg::ST_MUL_A: begin
        ctl.mul_en = 1'b1;
        state_nxt = msr_pkg::ST_OUT_A;
      end
      msr_pkg::ST_OUT_A: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) state_nxt = msr_pkg::ST_UPD;
      end
      msr_pkg::ST_UPD: begin
        do_upd = 1'b1;
        if (last_r && seen_r != 2'd0) state_nxt = msr_pkg::ST_MUL_B;
        else state_nxt = msr_pkg::ST_IDLE;
        if (last_r && seen_r == 2'd0) clear_all = 1'b1;
      end
      msr_pkg::ST_MUL_B: begin
        ctl.mul_en = 1'b1;
        state_nxt = msr_pkg::ST_OUT_B;
      end
      msr_pkg::ST_OUT_B: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          clear_all = 1'b1;
          state_nxt = msr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msr_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Window, held slopes and cell count.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all || (accept && in_ch.first_cell)) begin
      for (int i = 0; i < 6; i++) win_val_r[i] <= '0;
      for (int i = 0; i < 2; i++) win_w_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        held_edge_r[i] <= '0;
        held_cell_r[i] <= '0;
      end
      seen_r <= '0;
    end else if (do_upd) begin
      for (int i = 0; i < 3; i++) begin
        held_edge_r[i] <= (seen_r == 2'd0) ? '0 : edge_s[i];
        held_cell_r[i] <= (seen_r == 2'd0) ? '0 : cell_s[i];
        win_val_r[i] <= win_val_r[3+i];
        win_val_r[3+i] <= cur_val_r[i];
      end
      win_w_r[0] <= win_w_r[1];
      win_w_r[1] <= cur_w_r;
      if (!last_r && seen_r != 2'd2) seen_r <= seen_r + 2'd1;
    end
  end

  // Captured cell.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_val_r[0] <= in_ch.density;
      cur_val_r[1] <= in_ch.pressure;
      cur_val_r[2] <= in_ch.celerity;
      cur_w_r <= in_ch.cell_width;
      last_r <= in_ch.last_cell;
    end
  end

  for (genvar j = 0; j < msr_pkg::Lanes; j++) begin : g_lane
    msr_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .cur       (cur_val_r[j]),
      .prev      (win_val_r[3+j]),
      .den       (den),
      .held_edge (held_edge_r[j]),
      .lv        (win_val_r[j]),
      .lw        (win_w_r[0]),
      .ls        (held_cell_r[j]),
      .rv        (win_val_r[3+j]),
      .rw        (win_w_r[1]),
      .rs_zero   (state_r == msr_pkg::ST_MUL_B),
      .edge_slope(edge_s[j]),
      .cell_slope(cell_s[j]),
      .res       (res[j])
    );
  end

  // Merge of the lane results into one output transaction.
  assign out_ch.left_density = res[0].left;
  assign out_ch.left_pressure = res[1].left;
  assign out_ch.left_celerity = res[2].left;
  assign out_ch.right_density = res[0].right;
  assign out_ch.right_pressure = res[1].right;
  assign out_ch.right_celerity = res[2].right;
  assign out_ch.final_interface = (state_r == msr_pkg::ST_OUT_B);

endmodule

FILE: design/msr_chk.sv
// Port-level checker for the slope reconstruction, bound to the top level.
`timescale 1ns / 1ps
module msr_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_final
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  // The block never takes a cell while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // In the cycle after a cell is taken, input is closed.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input reopened at once");

  // The final interface of a frame closes the work on that cell.
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final |=> !out_valid) else $error("result after final");

endmodule

bind minmod_slope_reconstruction msr_chk u_msr_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_final(out_ch.final_interface)
);
